// ===== design/int32_alu_with_fold_check_macros.svh =====
// Assertion macros used by the ALU top module
`ifndef INT32_ALU_WITH_FOLD_CHECK_MACROS_SVH
`define INT32_ALU_WITH_FOLD_CHECK_MACROS_SVH

// Property that holds at every clock edge outside reset
`define ALU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/i32alu_pkg.sv =====
package i32alu_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned CmdWidth = 4;

    localparam logic [CmdWidth-1:0] CmdAdd = 4'd0;
    localparam logic [CmdWidth-1:0] CmdSub = 4'd1;
    localparam logic [CmdWidth-1:0] CmdMul = 4'd2;
    localparam logic [CmdWidth-1:0] CmdDiv = 4'd3;
    localparam logic [CmdWidth-1:0] CmdMod = 4'd4;
    localparam logic [CmdWidth-1:0] CmdEq  = 4'd5;
    localparam logic [CmdWidth-1:0] CmdNe  = 4'd6;
    localparam logic [CmdWidth-1:0] CmdLt  = 4'd7;
    localparam logic [CmdWidth-1:0] CmdGt  = 4'd8;
    localparam logic [CmdWidth-1:0] CmdLe  = 4'd9;
    localparam logic [CmdWidth-1:0] CmdGe  = 4'd10;
    localparam logic [CmdWidth-1:0] CmdAnd = 4'd11;
    localparam logic [CmdWidth-1:0] CmdOr  = 4'd12;
    localparam logic [CmdWidth-1:0] CmdXor = 4'd13;
    localparam logic [CmdWidth-1:0] CmdShl = 4'd14;
    localparam logic [CmdWidth-1:0] CmdShr = 4'd15;

    typedef struct packed {
        logic [CmdWidth-1:0]         command;
        logic signed [DataWidth-1:0] left_operand;
        logic signed [DataWidth-1:0] right_operand;
    } in_item_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic                        folded;
    } out_item_t;

endpackage

// ===== design/int32_alu_with_fold_check.sv =====
// Channel | valid    | ready    | payload
// in      | in_valid | in_ready | in_data  (i32alu_pkg::in_item_t)
// out     | out_valid| out_ready| out_data (i32alu_pkg::out_item_t)
//
// One item per cycle while the output is not stalled; a result passes
// the front stage, the divider and the output reg before it is valid.
// The divider resolves one quotient bit per stage; all ops
// share the same path so results leave in order.
// Reset clears all valid bits; payload registers are not reset.
// Stall: the whole pipe freezes when the output holds an item that is
// not taken; in_ready follows the same enable.
`include "int32_alu_with_fold_check_macros.svh"
module int32_alu_with_fold_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i32alu_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i32alu_pkg::out_item_t out_data
);
    // datapath width follows the payload types
    localparam int unsigned DATA_WIDTH = i32alu_pkg::DataWidth;
    localparam int unsigned CW    = i32alu_pkg::CmdWidth;
    // tag: cmd, ok, neg quotient, neg remainder, fast value, product
    localparam int unsigned TAG_W = CW + 3 + 2 * DATA_WIDTH;

    logic                  en;
    logic                  f_vld, f_ok, f_nq, f_nr;
    logic [CW-1:0]         f_cmd;
    logic [DATA_WIDTH-1:0] f_fast, f_ma, f_mb, f_mul;
    logic                  d_vld;
    logic [DATA_WIDTH-1:0] d_quo, d_rem;
    logic [TAG_W-1:0]      d_tag;

    logic                  t_ok, t_nq, t_nr;
    logic [CW-1:0]         t_cmd;
    logic [DATA_WIDTH-1:0] t_fast, t_mul;

    logic                  ov_reg;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic                  fold_reg;

    // Advance whenever the output register is empty or being drained.
    assign en       = !ov_reg || out_ready;
    assign in_ready = en;

    i32alu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .command   (in_data.command),
        .a         (in_data.left_operand),
        .b         (in_data.right_operand),
        .out_valid (f_vld),
        .cmd_q     (f_cmd),
        .fast_q    (f_fast),
        .ok_q      (f_ok),
        .neg_q_q   (f_nq),
        .neg_r_q   (f_nr),
        .mag_a_q   (f_ma),
        .mag_b_q   (f_mb),
        .mul_q     (f_mul)
    );

    i32alu_divpipe #(.W(DATA_WIDTH), .TAG_W(TAG_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_vld),
        .dividend  (f_ma),
        .divisor   (f_mb),
        .in_tag    ({f_cmd, f_ok, f_nq, f_nr, f_fast, f_mul}),
        .out_valid (d_vld),
        .quotient  (d_quo),
        .remainder (d_rem),
        .out_tag   (d_tag)
    );

    assign {t_cmd, t_ok, t_nq, t_nr, t_fast, t_mul} = d_tag;

    // Final select; sign fix for divide and modulo, refused reads zero.
    always_comb
    begin
        case (t_cmd)
            i32alu_pkg::CmdMul: val_next = t_mul;
            i32alu_pkg::CmdDiv: val_next = t_nq ? (~d_quo + 1'b1) : d_quo;
            i32alu_pkg::CmdMod: val_next = t_nr ? (~d_rem + 1'b1) : d_rem;
            default:            val_next = t_fast;
        endcase
        if (!t_ok)
            val_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg  <= val_next;
            fold_reg <= t_ok;
        end
    end

    assign out_valid = ov_reg;
    always_comb
    begin
        out_data.value  = val_reg;
        out_data.folded = fold_reg;
    end

    `ALU_ASSERT(a_refused_zero, clk, rst_n, !out_valid || fold_reg || val_reg == '0,
        "refused item has nonzero value")
    `ALU_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(val_reg), "stalled result changed")
    `ALU_ASSERT(a_ready_link, clk, rst_n, in_ready == (!out_valid || out_ready),
        "input ready not tied to output drain")
endmodule

// ===== design/i32alu_divpipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a side tag of TAG_W bits alongside each item.
module i32alu_divpipe #(
    parameter int unsigned W     = 32,
    parameter int unsigned TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     dividend,
    input  logic [W-1:0]     divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [W-1:0]     quotient,
    output logic [W-1:0]     remainder,
    output logic [TAG_W-1:0] out_tag
);
    logic             vld_reg [W];
    logic [W-1:0]     rem_reg [W];
    logic [W-1:0]     quo_reg [W];
    logic [W-1:0]     dsr_reg [W];
    logic [TAG_W-1:0] tag_reg [W];

    for (genvar s = 0; s < W; s++)
    begin : g_stage
        logic             vld_cur;
        logic [W-1:0]     rem_cur;
        logic [W-1:0]     quo_cur;
        logic [W-1:0]     dsr_cur;
        logic [TAG_W-1:0] tag_cur;
        logic [W:0]       trial;
        logic [W-1:0]     rem_next;
        logic [W-1:0]     quo_next;

        // first stage starts from a zero partial remainder
        if (s == 0)
        begin : g_head
            assign vld_cur = in_valid;
            assign rem_cur = '0;
            assign quo_cur = dividend;
            assign dsr_cur = divisor;
            assign tag_cur = in_tag;
        end
        else
        begin : g_body
            assign vld_cur = vld_reg[s-1];
            assign rem_cur = rem_reg[s-1];
            assign quo_cur = quo_reg[s-1];
            assign dsr_cur = dsr_reg[s-1];
            assign tag_cur = tag_reg[s-1];
        end

        always_comb
        begin
            trial = {rem_cur, quo_cur[W-1]} - {1'b0, dsr_cur};
            if (trial[W])
            begin
                rem_next = {rem_cur[W-2:0], quo_cur[W-1]};
                quo_next = {quo_cur[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_cur[W-2:0], 1'b1};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                dsr_reg[s] <= dsr_cur;
                tag_reg[s] <= tag_cur;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign quotient  = quo_reg[W-1];
    assign remainder = rem_reg[W-1];
    assign out_tag   = tag_reg[W-1];
endmodule

// ===== design/i32alu_front.sv =====
// Stage 1: decode, fast ops, product, operand magnitudes, sign and refusal flags.
module i32alu_front #(
    parameter int unsigned DATA_WIDTH = i32alu_pkg::DataWidth
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [i32alu_pkg::CmdWidth-1:0]   command,
    input  logic [DATA_WIDTH-1:0]             a,
    input  logic [DATA_WIDTH-1:0]             b,
    output logic                              out_valid,
    output logic [i32alu_pkg::CmdWidth-1:0]   cmd_q,
    output logic [DATA_WIDTH-1:0]             fast_q,
    output logic                              ok_q,
    output logic                              neg_q_q,
    output logic                              neg_r_q,
    output logic [DATA_WIDTH-1:0]             mag_a_q,
    output logic [DATA_WIDTH-1:0]             mag_b_q,
    output logic [DATA_WIDTH-1:0]             mul_q
);
    localparam int unsigned SHW = $clog2(DATA_WIDTH);

    logic                  vld_reg;
    logic [i32alu_pkg::CmdWidth-1:0] cmd_reg;
    logic [DATA_WIDTH-1:0] fast_reg, fast_next;
    logic                  ok_reg, ok_next;
    logic                  nq_reg, nr_reg;
    logic [DATA_WIDTH-1:0] ma_reg, mb_reg, mul_reg;
    logic                  lt, sh_bad, min_m1, b_zero;
    logic [SHW-1:0]        sh;

    always_comb
    begin
        lt      = $signed(a) < $signed(b);
        sh_bad  = b[DATA_WIDTH-1] || (b >= DATA_WIDTH'(DATA_WIDTH));
        sh      = b[SHW-1:0];
        b_zero  = (b == '0);
        min_m1  = (a == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (b == '1);
        ok_next = 1'b1;
        fast_next = '0;
        case (command)
            i32alu_pkg::CmdAdd: fast_next = a + b;
            i32alu_pkg::CmdSub: fast_next = a - b;
            i32alu_pkg::CmdMul: fast_next = '0;
            i32alu_pkg::CmdDiv: ok_next = !(b_zero || min_m1);
            i32alu_pkg::CmdMod: ok_next = !b_zero;
            i32alu_pkg::CmdEq:  fast_next = {{(DATA_WIDTH-1){1'b0}}, a == b};
            i32alu_pkg::CmdNe:  fast_next = {{(DATA_WIDTH-1){1'b0}}, a != b};
            i32alu_pkg::CmdLt:  fast_next = {{(DATA_WIDTH-1){1'b0}}, lt};
            i32alu_pkg::CmdGt:  fast_next = {{(DATA_WIDTH-1){1'b0}},
                                             $signed(b) < $signed(a)};
            i32alu_pkg::CmdLe:  fast_next = {{(DATA_WIDTH-1){1'b0}},
                                             !($signed(b) < $signed(a))};
            i32alu_pkg::CmdGe:  fast_next = {{(DATA_WIDTH-1){1'b0}}, !lt};
            i32alu_pkg::CmdAnd: fast_next = a & b;
            i32alu_pkg::CmdOr:  fast_next = a | b;
            i32alu_pkg::CmdXor: fast_next = a ^ b;
            i32alu_pkg::CmdShl:
            begin
                ok_next   = !sh_bad;
                fast_next = a << sh;
            end
            i32alu_pkg::CmdShr:
            begin
                ok_next   = !sh_bad;
                fast_next = $unsigned($signed(a) >>> sh);
            end
            default: fast_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg  <= command;
            fast_reg <= fast_next;
            ok_reg   <= ok_next;
            nq_reg   <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            nr_reg   <= a[DATA_WIDTH-1];
            ma_reg   <= a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
            mb_reg   <= b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
            mul_reg  <= a * b;
        end
    end

    assign out_valid = vld_reg;
    assign cmd_q     = cmd_reg;
    assign fast_q    = fast_reg;
    assign ok_q      = ok_reg;
    assign neg_q_q   = nq_reg;
    assign neg_r_q   = nr_reg;
    assign mag_a_q   = ma_reg;
    assign mag_b_q   = mb_reg;
    assign mul_q     = mul_reg;
endmodule
